// ----- src/spq_pkg.sv -----
// spq_pkg: shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_core. No dependencies.
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH_DEF         = 128;
  localparam int unsigned PRIORITY_BITS_DEF = 16;

  // fixed field widths at the ports
  localparam int unsigned PRIO_PORT_W = 16;
  localparam int unsigned KEY_W       = 8;
  localparam int unsigned PAYLOAD_W   = 8;
  localparam int unsigned COUNT_W     = 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // shift-in of a new entry
    logic rem;  // shift all entries toward cell 0
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/spq_cell.sv -----
// spq_cell: one slot of the sorted chain, holding {priority, key, payload}.
// Depends on spq_pkg for the command struct and field widths.
`default_nettype none

module spq_cell #(
  parameter int unsigned PRIO_W = spq_pkg::PRIORITY_BITS_DEF,
  localparam int unsigned EW    = PRIO_W + spq_pkg::KEY_W + spq_pkg::PAYLOAD_W
) (
  input  wire logic              clk,
  input  wire spq_pkg::cell_ctl_t ctl,
  input  wire logic              valid,      // slot is below the fill count
  input  wire logic [EW-1:0]     new_ent,    // entry being inserted
  input  wire logic              prev_stay,  // neighbor toward cell 0 keeps its entry
  input  wire logic [EW-1:0]     prev_ent,   // neighbor toward cell 0
  input  wire logic [EW-1:0]     next_ent,   // neighbor away from cell 0
  output logic                   stay,
  output logic [EW-1:0]          ent
);

  localparam int unsigned LOW_W = spq_pkg::KEY_W + spq_pkg::PAYLOAD_W;

  logic [EW-1:0]                ent_r;
  logic [EW-1:0]                ent_nxt;
  logic [PRIO_W-1:0]            my_prio;
  logic [PRIO_W-1:0]            new_prio;
  logic [spq_pkg::KEY_W-1:0]    my_key;
  logic [spq_pkg::KEY_W-1:0]    new_key;

  assign my_prio  = ent_r[EW-1:LOW_W];
  assign new_prio = new_ent[EW-1:LOW_W];
  assign my_key   = ent_r[LOW_W-1:spq_pkg::PAYLOAD_W];
  assign new_key  = new_ent[LOW_W-1:spq_pkg::PAYLOAD_W];

  // cell 0 holds the tail; an entry stays put if it leaves before the new one
  assign stay = valid && ((new_prio > my_prio) ||
                          ((new_prio == my_prio) && (new_key <= my_key)));

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.rem) begin
      ent_nxt = next_ent;
    end else if (ctl.ins && !stay) begin
      ent_nxt = prev_stay ? new_ent : prev_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

// ----- src/sorted_priority_queue_core.sv -----
// sorted_priority_queue_core: bounded priority queue as a chain of sorted cells.
// Depends on spq_pkg and spq_cell.
//
//  channel | dir | beat fields (low bit first)
//  --------+-----+--------------------------------------------------------------
//  in_     | in  | tuser: operation; tdata: priority_req, key, payload
//  out_    | out | tuser: status; tdata: out_priority, out_key, out_payload, count
//
// One operation per cycle: every cell compares and shifts in the accept cycle.
// The result is registered and appears the cycle after the input beat.
// A new beat is taken while a result waits only if that result leaves the
// same cycle; otherwise in_tready drops until out_tready.
// rst_n (sync, active low) empties the queue and clears out_tvalid.
`default_nettype none

module sorted_priority_queue_core #(
  parameter int unsigned DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [0:0]  in_tuser,   // [0] operation
  input  wire logic [31:0] in_tdata,   // [15:0] priority_req, [23:16] key, [31:24] payload
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic [39:0]      out_tdata   // [15:0] out_priority, [23:16] out_key,
                                       // [31:24] out_payload, [39:32] count
);

  localparam int unsigned KW    = spq_pkg::KEY_W;
  localparam int unsigned PW    = spq_pkg::PAYLOAD_W;
  localparam int unsigned PPW   = spq_pkg::PRIO_PORT_W;
  localparam int unsigned EW    = PRIORITY_BITS + KW + PW;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                    accept;
  logic                    is_remove;
  logic                    full;
  logic                    empty;
  spq_pkg::cell_ctl_t      ctl;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [1:0]              status_r;
  logic [1:0]              status_nxt;
  logic [PPW-1:0]          oprio_r;
  logic [PPW-1:0]          oprio_nxt;
  logic [KW-1:0]           okey_r;
  logic [KW-1:0]           okey_nxt;
  logic [PW-1:0]           opay_r;
  logic [PW-1:0]           opay_nxt;
  logic [CNT_W-1:0]        ocount_r;
  logic [PRIORITY_BITS+PPW-1:0] prio_ext;
  logic [PRIORITY_BITS+PPW-1:0] tail_prio_ext;
  logic [CNT_W+spq_pkg::COUNT_W-1:0] count_ext;
  logic [EW-1:0]           new_ent;
  logic [EW-1:0]           ent  [DEPTH];
  logic                    stay [DEPTH];
  logic [DEPTH-1:0]        valid;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign is_remove = (in_tuser[0] == spq_pkg::OP_REMOVE);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  assign ctl.ins = accept && !is_remove && !full;
  assign ctl.rem = accept && is_remove && !empty;

  // priority kept to PRIORITY_BITS bits
  assign prio_ext = {{PRIORITY_BITS{1'b0}}, in_tdata[15:0]};
  assign new_ent  = {prio_ext[PRIORITY_BITS-1:0], in_tdata[23:16], in_tdata[31:24]};

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    assign valid[j] = (CNT_W'(j) < count_r);

    if (j == 0) begin : g_first
      spq_cell #(.PRIO_W(PRIORITY_BITS)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .valid     (valid[j]),
        .new_ent   (new_ent),
        .prev_stay (1'b1),
        .prev_ent  (ent[j]),
        .next_ent  (ent[(j+1) % DEPTH]),
        .stay      (stay[j]),
        .ent       (ent[j])
      );
    end else if (j == DEPTH - 1) begin : g_last
      spq_cell #(.PRIO_W(PRIORITY_BITS)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .valid     (valid[j]),
        .new_ent   (new_ent),
        .prev_stay (stay[j-1]),
        .prev_ent  (ent[j-1]),
        .next_ent  (ent[j]),
        .stay      (stay[j]),
        .ent       (ent[j])
      );
    end else begin : g_mid
      spq_cell #(.PRIO_W(PRIORITY_BITS)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .valid     (valid[j]),
        .new_ent   (new_ent),
        .prev_stay (stay[j-1]),
        .prev_ent  (ent[j-1]),
        .next_ent  (ent[j+1]),
        .stay      (stay[j]),
        .ent       (ent[j])
      );
    end
  end

  // cell 0 is always the tail
  assign tail_prio_ext = {{PPW{1'b0}}, ent[0][EW-1:KW+PW]};

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    oprio_nxt     = oprio_r;
    okey_nxt      = okey_r;
    opay_nxt      = opay_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = spq_pkg::ST_OK;
      oprio_nxt     = '0;
      okey_nxt      = '0;
      opay_nxt      = '0;
      if (is_remove) begin
        if (empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          oprio_nxt = tail_prio_ext[PPW-1:0];
          okey_nxt  = ent[0][KW+PW-1:PW];
          opay_nxt  = ent[0][PW-1:0];
        end
      end else begin
        if (full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    oprio_r  <= oprio_nxt;
    okey_r   <= okey_nxt;
    opay_r   <= opay_nxt;
    if (accept) begin
      ocount_r <= count_nxt;
    end
  end

  assign count_ext  = {{spq_pkg::COUNT_W{1'b0}}, ocount_r};
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {count_ext[spq_pkg::COUNT_W-1:0], opay_r, okey_r, oprio_r};

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// tb: self-checking bench for sorted_priority_queue_core with a scoreboard that
// keeps its own sorted copy of the queue and predicts each result beat.
// Depends on spq_pkg and the core RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH    = spq_pkg::DEPTH_DEF;
  localparam int unsigned ITEMS     = 950;
  localparam int unsigned HOLD_AT   = 400;   // out beats before the long back-pressure
  localparam int unsigned HOLD_LEN  = 500;   // cycles of out_tready low
  localparam int unsigned CALM_LO   = 1500;  // cycle window with no idling on either side
  localparam int unsigned CALM_HI   = 2100;

  typedef struct packed {
    logic [15:0] prio;
    logic [7:0]  key;
    logic [7:0]  payload;
  } entry_t;

  typedef struct packed {
    spq_pkg::status_t status;
    logic [15:0] prio;
    logic [7:0]  key;
    logic [7:0]  payload;
    logic [7:0]  count;
  } outcome_t;

  class queue_scoreboard;
    entry_t      slots[QDEPTH];
    int unsigned level;
    outcome_t    awaited[$];
    int unsigned errors;

    function new();
      level  = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // predict the result of one accepted in_ beat
    function void note_input(logic [0:0] tuser, logic [31:0] tdata);
      entry_t      fresh;
      outcome_t    res;
      int unsigned pos;
      fresh.prio    = tdata[15:0];
      fresh.key     = tdata[23:16];
      fresh.payload = tdata[31:24];
      res   = '0;
      res.status = spq_pkg::ST_OK;
      if (spq_pkg::op_t'(tuser[0]) == spq_pkg::OP_INSERT) begin
        if (level >= QDEPTH) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < level && fresh.prio < slots[pos].prio) pos++;
          // equal priority: ascending key; a full tie leaves after older entries
          while (pos < level && fresh.prio == slots[pos].prio && fresh.key > slots[pos].key)
            pos++;
          for (int unsigned n = level; n > pos; n--) slots[n] = slots[n-1];
          slots[pos] = fresh;
          level++;
        end
      end else begin
        if (level == 0) begin
          res.status = spq_pkg::ST_EMPTY;
        end else begin
          level--;
          res.prio    = slots[level].prio;
          res.key     = slots[level].key;
          res.payload = slots[level].payload;
        end
      end
      res.count = level[7:0];
      awaited.push_back(res);
    endfunction

    function void field_ok(string name, logic [15:0] exp, logic [15:0] got);
      if (exp !== got) begin
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] tuser, logic [39:0] tdata);
      outcome_t exp;
      if (awaited.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual %0h/%0h",
                 $time, tuser, tdata);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      field_ok("status",  16'(exp.status),  16'(tuser));
      field_ok("priority", exp.prio,        tdata[15:0]);
      field_ok("key",      16'(exp.key),     16'(tdata[23:16]));
      field_ok("payload",  16'(exp.payload), 16'(tdata[31:24]));
      field_ok("count",    16'(exp.count),   16'(tdata[39:32]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [0:0]  in_tuser = '0;   // [0] operation
  logic [31:0] in_tdata = '0;   // [15:0] priority_req, [23:16] key, [31:24] payload
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;       // [1:0] status
  logic [39:0] out_tdata;       // [15:0] priority, [23:16] key, [31:24] payload, [39:32] count

  int unsigned cyc = 0;
  int unsigned lvl = 0;         // sender-side occupancy, for steering the stimulus
  int unsigned sent = 0;

  queue_scoreboard sb = new();

  sorted_priority_queue_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit calm();
    return cyc >= CALM_LO && cyc < CALM_HI;
  endfunction

  // beat monitors
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin : rx
    int unsigned beats;
    int unsigned hold;
    bit          held;
    beats = 0;
    hold  = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) beats++;
      if (!held && beats >= HOLD_AT) begin
        held = 1'b1;
        hold = HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm() || ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic send_item(spq_pkg::op_t op, logic [15:0] pr, logic [7:0] ky,
                           logic [7:0] pl);
    while (!calm() && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pl, ky, pr};
    do @(posedge clk); while (!in_tready);
    if (op == spq_pkg::OP_INSERT && lvl < QDEPTH) lvl++;
    if (op == spq_pkg::OP_REMOVE && lvl > 0) lvl--;
    sent++;
  endtask

  task automatic send_random(int unsigned ins_pct);
    spq_pkg::op_t op;
    logic [15:0]  pr;
    logic [7:0]   ky;
    op = ($urandom_range(99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
    // a quarter of the beats use a tiny range so ties are common
    if ($urandom_range(3) == 0) begin
      pr = 16'($urandom_range(3));
      ky = 8'($urandom_range(3));
    end else begin
      pr = 16'($urandom);
      ky = 8'($urandom);
    end
    send_item(op, pr, ky, 8'($urandom));
  endtask

  // hold the input off until every predicted result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    forever begin
      @(negedge clk);
      if (sb.pending() == 0) break;
    end
    @(posedge clk);
  endtask

  initial begin : stim
    int unsigned phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty remove, field extremes, priority and key ties
    send_item(spq_pkg::OP_REMOVE, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(spq_pkg::OP_INSERT, 16'h0000, 8'h00, 8'h00);
    send_item(spq_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(spq_pkg::OP_INSERT, 16'hFFFF, 8'h00, 8'hA5);
    send_item(spq_pkg::OP_INSERT, 16'h8000, 8'h80, 8'h5A);
    send_item(spq_pkg::OP_INSERT, 16'h1234, 8'h07, 8'h01);
    send_item(spq_pkg::OP_INSERT, 16'h1234, 8'h07, 8'h02);
    send_item(spq_pkg::OP_INSERT, 16'h1234, 8'h07, 8'h03);
    send_item(spq_pkg::OP_INSERT, 16'h1234, 8'h06, 8'h04);
    send_item(spq_pkg::OP_INSERT, 16'h1234, 8'h08, 8'h05);
    repeat (10) send_item(spq_pkg::OP_REMOVE, 16'h0000, 8'h00, 8'h00);
    wait_drained();

    // random: fill to full and past it, mixed traffic, drain to empty and past it
    sent  = 0;
    phase = 0;
    while (sent < ITEMS) begin
      case (phase % 4)
        0: begin
          while (lvl < QDEPTH && sent < ITEMS) send_random(80);
          repeat (6) send_random(100);
        end
        2: begin
          while (lvl > 0 && sent < ITEMS) send_random(20);
          repeat (6) send_random(0);
        end
        default: begin
          for (int k = 0; k < 150 && sent < ITEMS; k++) send_random(50);
        end
      endcase
      wait_drained();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
